/* design/lbf_pkg.sv */
// ----------------------------------------------------------------------------
// lbf_pkg
// Shared widths, constants, codes and the controller command word for the
// LED breathe / flicker effect block.
// ----------------------------------------------------------------------------
package lbf_pkg;

	localparam int unsigned TS_W    = 32;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned IVL_W   = 16;
	localparam int unsigned SEED_W  = 16;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 16;

	localparam logic [MODE_W-1:0] MODE_FIXED   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BREATH  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLICKER = 2'd2;

	localparam logic [ADDR_W-1:0] REG_MODE      = 3'd0;
	localparam logic [ADDR_W-1:0] REG_MAX_LEVEL = 3'd1;
	localparam logic [ADDR_W-1:0] REG_MIN_LEVEL = 3'd2;
	localparam logic [ADDR_W-1:0] REG_BREATH_IV = 3'd3;
	localparam logic [ADDR_W-1:0] REG_FLICK_IV  = 3'd4;

	localparam logic [SEED_W-1:0]  LCG_MUL        = 16'd2053;
	localparam logic [SEED_W-1:0]  LCG_ADD        = 16'd13849;
	localparam logic [SEED_W-1:0]  SEED_RST       = 16'd1337;
	localparam logic [IVL_W-1:0]   BREATH_IV_RST  = 16'd4000;
	localparam logic [IVL_W-1:0]   FLICK_IV_RST   = 16'd48000;
	localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST  = 8'd255;
	localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST  = 8'd2;
	localparam logic [LEVEL_W-1:0] FLICK_LVL_RST  = 8'd255;
	localparam logic [3:0]         FLICK_SPAN     = 4'd10;
	localparam logic [4:0]         FLICK_THRESH   = 5'd4;

	typedef struct packed {
		logic load;
		logic calc;
		logic commit;
	} lbf_cmd_t;

endpackage

/* design/lbf_req_if.sv */
// ----------------------------------------------------------------------------
// lbf_req_if
// Timestamp channel: one microsecond timestamp per word.
// ----------------------------------------------------------------------------
interface lbf_req_if import lbf_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [TS_W-1:0]   now_us;

	modport source (output valid, output now_us, input ready);
	modport sink   (input valid, input now_us, output ready);
endinterface

/* design/lbf_rsp_if.sv */
// ----------------------------------------------------------------------------
// lbf_rsp_if
// Result channel: PWM level and changed flag, one word per timestamp.
// ----------------------------------------------------------------------------
interface lbf_rsp_if import lbf_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;
	logic               changed;

	modport source (output valid, output level, output changed, input ready);
	modport sink   (input valid, input level, input changed, output ready);
endinterface

/* design/lbf_cfg_if.sv */
// ----------------------------------------------------------------------------
// lbf_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lbf_cfg_if import lbf_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] addr;
	logic [DATA_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

/* design/lbf_ctrl.sv */
// ----------------------------------------------------------------------------
// lbf_ctrl
// Sequencer: capture, timer/LCG stage, commit. Owns the result valid flag.
// ----------------------------------------------------------------------------
module lbf_ctrl import lbf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output lbf_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CALC   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_vld_q;
	logic       out_free;
	logic       accept;

	assign out_free   = !out_vld_q || rsp_ready;
	assign req_ready  = (state_q == ST_IDLE) || ((state_q == ST_COMMIT) && out_free);
	assign accept     = req_valid && req_ready;
	assign cmd.load   = accept;
	assign cmd.calc   = (state_q == ST_CALC);
	assign cmd.commit = (state_q == ST_COMMIT) && out_free;
	assign rsp_valid  = out_vld_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_CALC;
			end
			ST_CALC: begin
				state_nxt = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (out_free) state_nxt = accept ? ST_CALC : ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) out_vld_q <= 1'b1;
			else if (rsp_ready) out_vld_q <= 1'b0;
		end
	end

endmodule

/* design/lbf_dp.sv */
// ----------------------------------------------------------------------------
// lbf_dp
// Datapath: registers, interval timer, breathing step, LCG and flicker draw,
// result register.
// ----------------------------------------------------------------------------
module lbf_dp import lbf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lbf_cmd_t           cmd,
	input  logic [TS_W-1:0]    now_us,
	input  logic               cfg_we,
	input  logic [ADDR_W-1:0]  cfg_addr,
	input  logic [DATA_W-1:0]  cfg_data,
	output logic [LEVEL_W-1:0] level,
	output logic               changed
);

	logic [MODE_W-1:0]  mode_q;
	logic [LEVEL_W-1:0] max_level_q;
	logic [LEVEL_W-1:0] min_level_q;
	logic [IVL_W-1:0]   breath_iv_q;
	logic [IVL_W-1:0]   flick_iv_q;

	logic [TS_W-1:0]    last_fire_q;
	logic [LEVEL_W-1:0] breath_q;
	logic               rising_q;
	logic [SEED_W-1:0]  seed_q;
	logic [LEVEL_W-1:0] flicker_q;
	logic [LEVEL_W-1:0] last_out_q;
	logic [LEVEL_W-1:0] level_q;
	logic               changed_q;

	logic [TS_W-1:0]    now_us_s1;
	logic [TS_W-1:0]    now_us_s2;
	logic               fire_s2;
	logic [SEED_W-1:0]  seed_s2;

	logic [TS_W-1:0]    elapsed;
	logic [IVL_W-1:0]   interval;
	logic [2*SEED_W-1:0] lcg_prod;
	logic [LEVEL_W-1:0] rnd;
	logic [11:0]        scaled;
	logic [4:0]         draw;
	logic [LEVEL_W-1:0] flick_nxt;
	logic [LEVEL_W-1:0] breath_nxt;
	logic               rising_nxt;
	logic [LEVEL_W-1:0] level_nxt;

	// timer and LCG
	assign interval = (mode_q == MODE_BREATH) ? breath_iv_q : flick_iv_q;
	assign elapsed  = now_us_s1 - last_fire_q;
	assign lcg_prod = seed_q * LCG_MUL;

	// flicker draw, 1..10
	assign rnd       = seed_s2[7:0] + seed_s2[15:8];
	assign scaled    = rnd * FLICK_SPAN;
	assign draw      = {1'b0, scaled[11:8]} + 5'd1;
	assign flick_nxt = (draw > FLICK_THRESH) ? max_level_q : '0;

	always_comb begin
		breath_nxt = rising_q ? breath_q + 8'd1 : breath_q - 8'd1;
		rising_nxt = rising_q;
		if (breath_nxt == max_level_q) rising_nxt = 1'b0;
		if (breath_nxt == min_level_q) rising_nxt = 1'b1;
	end

	always_comb begin
		case (mode_q)
			MODE_BREATH:  level_nxt = fire_s2 ? breath_nxt : breath_q;
			MODE_FLICKER: level_nxt = fire_s2 ? flick_nxt : flicker_q;
			default:      level_nxt = max_level_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) now_us_s1 <= now_us;
		if (cmd.calc) begin
			now_us_s2 <= now_us_s1;
			fire_s2   <= (elapsed >= {{(TS_W-IVL_W){1'b0}}, interval});
			seed_s2   <= lcg_prod[SEED_W-1:0] + LCG_ADD;
		end
		if (cmd.commit) begin
			level_q   <= level_nxt;
			changed_q <= (level_nxt != last_out_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_BREATH;
			max_level_q <= MAX_LEVEL_RST;
			min_level_q <= MIN_LEVEL_RST;
			breath_iv_q <= BREATH_IV_RST;
			flick_iv_q  <= FLICK_IV_RST;
			last_fire_q <= '0;
			breath_q    <= '0;
			rising_q    <= 1'b1;
			seed_q      <= SEED_RST;
			flicker_q   <= FLICK_LVL_RST;
			last_out_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_MODE:      mode_q      <= cfg_data[MODE_W-1:0];
					REG_MAX_LEVEL: max_level_q <= cfg_data[LEVEL_W-1:0];
					REG_MIN_LEVEL: min_level_q <= cfg_data[LEVEL_W-1:0];
					REG_BREATH_IV: breath_iv_q <= cfg_data[IVL_W-1:0];
					REG_FLICK_IV:  flick_iv_q  <= cfg_data[IVL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				last_out_q <= level_nxt;
				if (fire_s2 && (mode_q == MODE_BREATH)) begin
					last_fire_q <= now_us_s2;
					breath_q    <= breath_nxt;
					rising_q    <= rising_nxt;
				end
				if (fire_s2 && (mode_q == MODE_FLICKER)) begin
					last_fire_q <= now_us_s2;
					seed_q      <= seed_s2;
					flicker_q   <= flick_nxt;
				end
			end
		end
	end

	assign level   = level_q;
	assign changed = changed_q;

endmodule

/* design/led_breathe_flicker_effect_top.sv */
// ----------------------------------------------------------------------------
// led_breathe_flicker_effect_top
// LED effect generator: fixed, breathing or flicker PWM level per timestamp.
// ----------------------------------------------------------------------------
// req carries one microsecond timestamp per word; rsp returns one word per
// timestamp holding the PWM level and a flag set when it differs from the
// previous level. cfg writes the registers: 0 mode, 1 max level, 2 min level,
// 3 breathing interval, 4 flicker interval. cfg is always ready and must only
// be written while no timestamp is in flight.
// An accepted word passes a two-step sequence (timer compare and LCG
// multiply, then scaling multiply and state update) before its result is
// registered for rsp; the next timestamp is taken in the update step.
// The result sits in an output register, so the next timestamp is taken
// while the previous result waits. If rsp stalls, the second item holds in
// its update step and req is held off until the output register frees.
// Reset restores all registers and effect state to their defaults and
// empties the output register.
// ----------------------------------------------------------------------------
module led_breathe_flicker_effect_top import lbf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	lbf_req_if.sink   req,
	lbf_rsp_if.source rsp,
	lbf_cfg_if.sink   cfg
);

	lbf_cmd_t cmd;

	assign cfg.ready = 1'b1;

	lbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	lbf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.now_us   (req.now_us),
		.cfg_we   (cfg.valid),
		.cfg_addr (cfg.addr),
		.cfg_data (cfg.data),
		.level    (rsp.level),
		.changed  (rsp.changed)
	);

endmodule

/* design/lbf_checker.sv */
// ----------------------------------------------------------------------------
// lbf_checker
// Port-level checks for the LED effect block, bound to the top level.
// ----------------------------------------------------------------------------
module lbf_checker import lbf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [LEVEL_W-1:0] rsp_level,
	input logic               rsp_changed
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("req accepted on consecutive cycles");

	a_rise_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
		else $error("result without a timestamp three cycles earlier");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> ($stable(rsp_level) && $stable(rsp_changed)))
		else $error("rsp word changed while stalled");

endmodule

bind led_breathe_flicker_effect_top lbf_checker u_lbf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_level   (rsp.level),
	.rsp_changed (rsp.changed)
);
